/* rtl/oaht_pkg.sv */
// Shared types and constants of the open-addressing hash table.
`default_nettype none

package oaht_pkg;

  // Field widths of the request and result channels.
  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int VAL_W   = 64;
  localparam int LOAD_W  = 8;
  localparam int USED_W  = 9;

  // Load limit after reset: three quarters of 256 slots.
  localparam logic [LOAD_W-1:0] LOAD_LIMIT_RST = 8'd192;

  // Request operations.
  localparam logic [1:0] ACT_GET = 2'd0;
  localparam logic [1:0] ACT_SET = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;

  // Slot marks. Any mark that is neither empty nor tombstone counts as live.
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // Controller states. S_HASH, S_REM and S_FOLD reduce the hash modulo the slot count.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_REM,
    S_FOLD,
    S_SEEK,
    S_PROBE
  } state_t;

  // One word of the slot memory: mark and key handle.
  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

`default_nettype wire

/* rtl/open_addressing_hash_table_top.sv */
// Open-addressing hash table with linear probing, tombstones and a load limit.
`default_nettype none

// Key/value table of SLOTS entries. Each request (get, set, delete) returns one
// result. After reset the block runs a clearing pass over the slot memory and
// stalls requests during it. A request is then accepted, issues the first slot
// read and probes its slots in turn (the slot memory delivers one slot per
// cycle); when SLOTS is not a power of two, the hash is first reduced modulo
// SLOTS by a reciprocal multiplication, before the first slot read. Requests
// are handled one at a time; a finished result waits in the output register
// while the next request is accepted and probed.
module open_addressing_hash_table_top #(
  parameter int SLOTS = 256
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // Configuration port: load limit.
  input  wire                                cfg_we,
  input  wire  [oaht_pkg::LOAD_W-1:0]        cfg_wdata,
  // Request channel.
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [1:0]                         in_action,
  input  wire  [oaht_pkg::KEY_W-1:0]         in_key_id,
  input  wire  [oaht_pkg::HASH_W-1:0]        in_key_hash,
  input  wire  [oaht_pkg::VAL_W-1:0]         in_write_value,
  // Result channel.
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_new_key,
  output logic [oaht_pkg::VAL_W-1:0]         out_read_value
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [oaht_pkg::HASH_W-1:0] SLOTS_W = oaht_pkg::HASH_W'(SLOTS);
  // Reciprocal of the slot count scaled by 2^32; the quotient it gives is at most one low.
  localparam logic [oaht_pkg::HASH_W-1:0] RECIP =
    oaht_pkg::HASH_W'((64'd1 << oaht_pkg::HASH_W) / SLOTS);

  // Registers.
  oaht_pkg::state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]                 cur_idx_r, cur_idx_nxt;
  logic [IDX_W-1:0]                 probe_cnt_r, probe_cnt_nxt;
  logic [oaht_pkg::HASH_W-1:0]      hash_r, hash_nxt;
  logic [oaht_pkg::HASH_W-1:0]      quot_r, quot_nxt;
  logic                             tomb_seen_r, tomb_seen_nxt;
  logic [IDX_W-1:0]                 tomb_idx_r, tomb_idx_nxt;
  logic [1:0]                       action_r;
  logic [oaht_pkg::KEY_W-1:0]       key_r;
  logic [oaht_pkg::VAL_W-1:0]       wval_r;
  logic [oaht_pkg::USED_W-1:0]      used_count_r, used_count_nxt;
  logic [oaht_pkg::LOAD_W-1:0]      load_limit_r;
  logic                             out_valid_r;
  logic [1:0]                       out_status_r;
  logic                             out_new_key_r;
  logic [oaht_pkg::VAL_W-1:0]       out_read_value_r;

  // Memories and their ports.
  oaht_pkg::slot_t                  slot_mem [SLOTS];
  logic [oaht_pkg::VAL_W-1:0]       val_mem  [SLOTS];
  oaht_pkg::slot_t                  slot_rdata_r;
  logic [oaht_pkg::VAL_W-1:0]       val_rdata_r;
  logic                             rd_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             slot_we;
  logic [IDX_W-1:0]                 slot_waddr;
  oaht_pkg::slot_t                  slot_wdata;
  logic                             val_we;
  logic [IDX_W-1:0]                 val_waddr;

  // Probe decision signals.
  logic                             in_acc;
  logic                             out_free;
  logic                             is_empty, is_tomb, is_hit, is_last;
  logic                             tomb_any;
  logic [IDX_W-1:0]                 tomb_at;
  logic [IDX_W-1:0]                 next_idx;
  logic                             done, commit;
  logic                             room;
  logic [1:0]                       res_status;
  logic                             res_new_key;
  logic [oaht_pkg::VAL_W-1:0]       res_rval;
  logic                             res_slot_we;
  logic [IDX_W-1:0]                 res_slot_addr;
  logic [1:0]                       res_mark;
  logic                             res_val_we;
  logic                             res_used_inc;
  logic [2*oaht_pkg::HASH_W-1:0]    quot_prod;

  assign in_stall       = (state_r != oaht_pkg::S_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_key    = out_new_key_r;
  assign out_read_value = out_read_value_r;
  assign out_free       = !out_valid_r || !out_stall;

  // Classify the slot whose data the memories deliver this cycle.
  assign is_empty = (slot_rdata_r.mark == oaht_pkg::MARK_EMPTY);
  assign is_tomb  = (slot_rdata_r.mark == oaht_pkg::MARK_TOMB);
  assign is_hit   = !is_empty && !is_tomb && (slot_rdata_r.key == key_r);
  assign is_last  = (probe_cnt_r == LAST_IDX);
  assign tomb_any = tomb_seen_r || is_tomb;
  assign tomb_at  = tomb_seen_r ? tomb_idx_r : cur_idx_r;
  assign next_idx = (cur_idx_r == LAST_IDX) ? '0 : cur_idx_r + IDX_W'(1);
  assign room     = (used_count_r < {1'b0, load_limit_r});

  assign done   = (action_r == oaht_pkg::ACT_NOP) || is_empty || is_hit || is_last;
  assign commit = (state_r == oaht_pkg::S_PROBE) && done && out_free;

  // Quotient estimate of the hash reduction: hash times the scaled reciprocal.
  assign quot_prod = {{oaht_pkg::HASH_W{1'b0}}, hash_r} * {{oaht_pkg::HASH_W{1'b0}}, RECIP};

  // Outcome of a finished probe.
  always_comb begin
    res_status    = oaht_pkg::STAT_OK;
    res_new_key   = 1'b0;
    res_rval      = '0;
    res_slot_we   = 1'b0;
    res_slot_addr = cur_idx_r;
    res_mark      = oaht_pkg::MARK_LIVE;
    res_val_we    = 1'b0;
    res_used_inc  = 1'b0;
    case (action_r)
      oaht_pkg::ACT_GET: begin
        if (is_hit) begin
          res_rval = val_rdata_r;
        end else begin
          res_status = oaht_pkg::STAT_MISSING;
        end
      end
      oaht_pkg::ACT_SET: begin
        if (is_hit) begin
          res_val_we = 1'b1;
        end else if (tomb_any) begin
          res_slot_we   = 1'b1;
          res_slot_addr = tomb_at;
          res_val_we    = 1'b1;
          res_new_key   = 1'b1;
        end else if (is_empty && room) begin
          res_slot_we  = 1'b1;
          res_val_we   = 1'b1;
          res_new_key  = 1'b1;
          res_used_inc = 1'b1;
        end else begin
          res_status = oaht_pkg::STAT_FULL;
        end
      end
      oaht_pkg::ACT_DEL: begin
        if (is_hit) begin
          res_slot_we = 1'b1;
          res_mark    = oaht_pkg::MARK_TOMB;
        end else begin
          res_status = oaht_pkg::STAT_MISSING;
        end
      end
      default: begin
        res_status = oaht_pkg::STAT_OK;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oaht_pkg::S_CLEAR: begin
        if (cur_idx_r == LAST_IDX) state_nxt = oaht_pkg::S_IDLE;
      end
      oaht_pkg::S_IDLE: begin
        if (in_acc) state_nxt = POW2 ? oaht_pkg::S_SEEK : oaht_pkg::S_HASH;
      end
      oaht_pkg::S_HASH: begin
        state_nxt = oaht_pkg::S_REM;
      end
      oaht_pkg::S_REM: begin
        state_nxt = oaht_pkg::S_FOLD;
      end
      oaht_pkg::S_FOLD: begin
        state_nxt = oaht_pkg::S_SEEK;
      end
      oaht_pkg::S_SEEK: begin
        state_nxt = oaht_pkg::S_PROBE;
      end
      oaht_pkg::S_PROBE: begin
        if (commit) state_nxt = oaht_pkg::S_IDLE;
      end
      default: begin
        state_nxt = oaht_pkg::S_IDLE;
      end
    endcase
  end

  // Memory port control per state.
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = cur_idx_r;
    slot_we    = 1'b0;
    slot_waddr = cur_idx_r;
    slot_wdata = '{mark: oaht_pkg::MARK_EMPTY, key: '0};
    val_we     = 1'b0;
    val_waddr  = cur_idx_r;
    unique case (state_r)
      oaht_pkg::S_CLEAR: begin
        slot_we = 1'b1;
      end
      oaht_pkg::S_SEEK: begin
        rd_en = 1'b1;
      end
      oaht_pkg::S_PROBE: begin
        rd_en      = 1'b1;
        rd_addr    = done ? cur_idx_r : next_idx;
        slot_we    = commit && res_slot_we;
        slot_waddr = res_slot_addr;
        slot_wdata = '{mark: res_mark, key: key_r};
        val_we     = commit && res_val_we;
        val_waddr  = res_slot_addr;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    cur_idx_nxt    = cur_idx_r;
    probe_cnt_nxt  = probe_cnt_r;
    hash_nxt       = hash_r;
    quot_nxt       = quot_r;
    tomb_seen_nxt  = tomb_seen_r;
    tomb_idx_nxt   = tomb_idx_r;
    used_count_nxt = used_count_r;
    case (state_r)
      oaht_pkg::S_CLEAR: begin
        cur_idx_nxt = next_idx;
      end
      oaht_pkg::S_IDLE: begin
        if (in_acc) begin
          cur_idx_nxt   = POW2 ? in_key_hash[IDX_W-1:0] : '0;
          hash_nxt      = in_key_hash;
          probe_cnt_nxt = '0;
          tomb_seen_nxt = 1'b0;
        end
      end
      oaht_pkg::S_HASH: begin
        quot_nxt = quot_prod[2*oaht_pkg::HASH_W-1:oaht_pkg::HASH_W];
      end
      oaht_pkg::S_REM: begin
        // Remainder estimate, below twice the slot count.
        hash_nxt = hash_r - quot_r * SLOTS_W;
      end
      oaht_pkg::S_FOLD: begin
        cur_idx_nxt = (hash_r >= SLOTS_W) ? IDX_W'(hash_r - SLOTS_W)
                                          : hash_r[IDX_W-1:0];
      end
      oaht_pkg::S_PROBE: begin
        if (!done) begin
          cur_idx_nxt   = next_idx;
          probe_cnt_nxt = probe_cnt_r + IDX_W'(1);
          if (is_tomb && !tomb_seen_r) begin
            tomb_seen_nxt = 1'b1;
            tomb_idx_nxt  = cur_idx_r;
          end
        end
        if (commit && res_used_inc) begin
          used_count_nxt = used_count_r + oaht_pkg::USED_W'(1);
        end
      end
      default: begin
        cur_idx_nxt = cur_idx_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= oaht_pkg::S_CLEAR;
      cur_idx_r    <= '0;
      used_count_r <= '0;
      load_limit_r <= oaht_pkg::LOAD_LIMIT_RST;
      out_valid_r  <= 1'b0;
      tomb_seen_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_idx_r    <= cur_idx_nxt;
      used_count_r <= used_count_nxt;
      tomb_seen_r  <= tomb_seen_nxt;
      if (cfg_we) load_limit_r <= cfg_wdata;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers of the request and the result.
  always_ff @(posedge clk) begin
    probe_cnt_r <= probe_cnt_nxt;
    hash_r      <= hash_nxt;
    quot_r      <= quot_nxt;
    tomb_idx_r  <= tomb_idx_nxt;
    if (in_acc) begin
      action_r <= in_action;
      key_r    <= in_key_id;
      wval_r   <= in_write_value;
    end
    if (commit) begin
      out_status_r     <= res_status;
      out_new_key_r    <= res_new_key;
      out_read_value_r <= res_rval;
    end
  end

  // Slot memory: mark and key, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (rd_en) slot_rdata_r <= slot_mem[rd_addr];
  end

  // Value memory, read alongside the slot memory.
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= wval_r;
    if (rd_en) val_rdata_r <= val_mem[rd_addr];
  end

  // The used count never passes the largest load limit.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r[oaht_pkg::USED_W-1] == 1'b0)
    else $error("used count exceeds load limit range");

  // A result appears only from a finished probe.
  a_out_from_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == oaht_pkg::S_PROBE))
    else $error("result without a finished probe");

  // Memory writes outside the clearing pass happen only when a probe commits.
  a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ((slot_we || val_we) && state_r != oaht_pkg::S_CLEAR) |-> commit)
    else $error("memory write without commit");

  // A committed request frees the controller on the next cycle.
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == oaht_pkg::S_IDLE))
    else $error("controller did not return to idle");

  // A new key is reported only with a successful status.
  a_new_key_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_new_key_r) |-> (out_status_r == oaht_pkg::STAT_OK))
    else $error("new key reported with failing status");

endmodule

`default_nettype wire
